// ===== hdl/dgi_pkg.sv =====
// Shared constants, types and tables of the gyro-driven rotation matrix update block.
`default_nettype none
package dgi_pkg;

   // Matrix element width (signed Q2.30) and field widths
   localparam int DATA_WIDTH   = 32;
   localparam int RATE_W       = 32;
   localparam int ANG_W        = 32;
   localparam int REQ_W        = 96;
   localparam int RSP_W        = 104;

   // Matrix update arithmetic
   localparam int PROD_W       = 64;
   localparam int RND_W        = 34;
   localparam int ACC_W        = 35;
   localparam int FRAC_SH      = 30;

   // Square root unit
   localparam int SQ_W         = 64;
   localparam int SQRT_CNT_W   = 5;

   // CORDIC unit
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W   = 6;
   localparam int CW           = 56;
   localparam int ZW           = 34;
   localparam int SCALE_SH     = 20;

   localparam logic signed [DATA_WIDTH-1:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic signed [ZW-1:0]         HALF_PI = 34'sd843314857;

   // Which product of an element update is in flight
   typedef enum logic [1:0] {
      TERM_SELF = 2'd0,
      TERM_ADD  = 2'd1,
      TERM_SUB  = 2'd2
   } term_type;

   // Which angle the CORDIC works on
   typedef enum logic [1:0] {
      ANG_ROLL  = 2'd0,
      ANG_PITCH = 2'd1,
      ANG_YAW   = 2'd2
   } angle_type;

   typedef struct packed {
      logic      load_in;
      logic      mul_go;
      logic [3:0] mul_elem;
      term_type  mul_term;
      logic      commit;
      logic      sq_go;
      logic      sqrt_init;
      logic      sqrt_step;
      logic      cordic_go;
      angle_type ang;
      logic      out_load;
   } dgi_cmd_type;

   typedef struct packed {
      logic sqrt_last;
      logic cordic_done;
   } dgi_stat_type;

   // Arctangent of 2^-i in Q3.29, rounded to nearest
   function automatic logic signed [ZW-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         6'd0:    v = 34'sd421657428;
         6'd1:    v = 34'sd248918915;
         6'd2:    v = 34'sd131521918;
         6'd3:    v = 34'sd66762579;
         6'd4:    v = 34'sd33510843;
         6'd5:    v = 34'sd16771758;
         6'd6:    v = 34'sd8387925;
         6'd7:    v = 34'sd4194219;
         6'd8:    v = 34'sd2097141;
         6'd9:    v = 34'sd1048575;
         6'd10:   v = 34'sd524288;
         6'd11:   v = 34'sd262144;
         6'd12:   v = 34'sd131072;
         6'd13:   v = 34'sd65536;
         6'd14:   v = 34'sd32768;
         6'd15:   v = 34'sd16384;
         6'd16:   v = 34'sd8192;
         6'd17:   v = 34'sd4096;
         6'd18:   v = 34'sd2048;
         6'd19:   v = 34'sd1024;
         6'd20:   v = 34'sd512;
         6'd21:   v = 34'sd256;
         6'd22:   v = 34'sd128;
         6'd23:   v = 34'sd64;
         6'd24:   v = 34'sd32;
         6'd25:   v = 34'sd16;
         6'd26:   v = 34'sd8;
         6'd27:   v = 34'sd4;
         6'd28:   v = 34'sd2;
         6'd29:   v = 34'sd1;
         6'd30:   v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Clip an angle to the 32 bit output range
   function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [ZW:0] v);
      logic signed [ANG_W-1:0] r;
      if (v > 35'sd2147483647)
         r = 32'sh7FFF_FFFF;
      else if (v < -35'sd2147483648)
         r = 32'sh8000_0000;
      else
         r = v[ANG_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/dgi_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle, gives atan2(y, x) in Q3.29.
`default_nettype none
module dgi_cordic (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [dgi_pkg::DATA_WIDTH-1:0] y_in,
   input  wire logic signed [dgi_pkg::DATA_WIDTH-1:0] x_in,
   output      logic                                  done,
   output      logic signed [dgi_pkg::ZW-1:0]         angle
);
   import dgi_pkg::*;

   logic signed [CW-1:0]       x_ff, x_in_v, y_ff, y_in_v;
   logic signed [ZW-1:0]       z_ff, z_in;
   logic [CORDIC_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                       run_ff, run_in, done_ff, done_in, zero_ff, zero_in;
   logic signed [CW-1:0]       xs, ys, dx, dy;

   // Scale the Q.30 inputs to Q.50
   assign xs = {{(CW-DATA_WIDTH-SCALE_SH){x_in[DATA_WIDTH-1]}}, x_in, {SCALE_SH{1'b0}}};
   assign ys = {{(CW-DATA_WIDTH-SCALE_SH){y_in[DATA_WIDTH-1]}}, y_in, {SCALE_SH{1'b0}}};
   assign dx = y_ff >>> cnt_ff;
   assign dy = x_ff >>> cnt_ff;

   // Load with quadrant correction, then rotate towards the x axis
   always_comb begin
      x_in_v  = x_ff;
      y_in_v  = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         zero_in = (xs == '0) && (ys == '0);
         cnt_in  = '0;
         run_in  = 1'b1;
         if (xs < 0) begin
            if (ys >= 0) begin
               x_in_v = ys;
               y_in_v = -xs;
               z_in   = HALF_PI;
            end else begin
               x_in_v = -ys;
               y_in_v = xs;
               z_in   = -HALF_PI;
            end
         end else begin
            x_in_v = xs;
            y_in_v = ys;
            z_in   = '0;
         end
      end else if (run_ff) begin
         if (!y_ff[CW-1]) begin
            x_in_v = x_ff + dx;
            y_in_v = y_ff - dy;
            z_in   = z_ff + atan_entry(ATAN_IDX_W'(cnt_ff));
         end else begin
            x_in_v = x_ff - dx;
            y_in_v = y_ff + dy;
            z_in   = z_ff - atan_entry(ATAN_IDX_W'(cnt_ff));
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CORDIC_CNT_W'(CORDIC_STEPS-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in_v;
      y_ff    <= y_in_v;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign angle = zero_ff ? '0 : z_ff;

endmodule
`default_nettype wire

// ===== hdl/dgi_datapath.sv =====
// Datapath: rotation matrix, shared multiplier, square root unit, CORDIC and result registers.
`default_nettype none
module dgi_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dgi_pkg::dgi_cmd_type                  cmd,
   output      dgi_pkg::dgi_stat_type                 stat,
   input  wire logic signed [dgi_pkg::RATE_W-1:0]     rate_x,
   input  wire logic signed [dgi_pkg::RATE_W-1:0]     rate_y,
   input  wire logic signed [dgi_pkg::RATE_W-1:0]     rate_z,
   output      logic signed [dgi_pkg::ANG_W-1:0]      roll_angle,
   output      logic signed [dgi_pkg::ANG_W-1:0]      pitch_angle,
   output      logic signed [dgi_pkg::ANG_W-1:0]      yaw_angle,
   output      logic                                  matrix_saturated
);
   import dgi_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_LSB = 64'sd536870912;
   localparam logic signed [ACC_W-1:0]  EL_MAX   = 35'sd2147483647;
   localparam logic signed [ACC_W-1:0]  EL_MIN   = -35'sd2147483648;
   localparam logic [SQ_W-1:0]          ONE_SQ   = 64'h1000_0000_0000_0000;

   logic signed [DATA_WIDTH-1:0] mat_ff [9];
   logic signed [DATA_WIDTH-1:0] nm_ff  [9];
   logic signed [RATE_W-1:0]     rate_ff [3];
   logic signed [PROD_W-1:0]     prod_ff;
   logic                         pvalid_ff;
   logic [3:0]                   pelem_ff;
   term_type                     pterm_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic                         sat_ff;
   logic [SQ_W-1:0]              v_ff, r_ff;
   logic [SQRT_CNT_W-1:0]        scnt_ff;
   logic signed [ANG_W-1:0]      roll_ff, pitch_ff, yaw_ff;
   logic signed [ANG_W-1:0]      roll_out_ff, pitch_out_ff, yaw_out_ff;
   logic                         sat_out_ff;

   logic [3:0]                   base;
   logic [1:0]                   col, ecol, axis;
   logic [3:0]                   midx;
   logic signed [DATA_WIDTH-1:0] mul_a, mul_b, cq;
   logic signed [PROD_W-1:0]     prod_bias, rnd_full;
   logic signed [RND_W-1:0]      rnd;
   logic signed [ACC_W-1:0]      diff;
   logic [SQ_W-1:0]              sbit, trial;
   logic [5:0]                   sshift;
   logic signed [DATA_WIDTH-1:0] cy, cx;
   logic                         cdone;
   logic signed [ZW-1:0]         cangle;

   // Row base and column of the element being updated
   always_comb begin
      case (cmd.mul_elem)
         4'd0:    begin base = 4'd0; col = 2'd0; end
         4'd1:    begin base = 4'd0; col = 2'd1; end
         4'd2:    begin base = 4'd0; col = 2'd2; end
         4'd3:    begin base = 4'd3; col = 2'd0; end
         4'd4:    begin base = 4'd3; col = 2'd1; end
         4'd5:    begin base = 4'd3; col = 2'd2; end
         4'd6:    begin base = 4'd6; col = 2'd0; end
         4'd7:    begin base = 4'd6; col = 2'd1; end
         default: begin base = 4'd6; col = 2'd2; end
      endcase
   end

   // Pick element column and gyro axis of the cross product term
   always_comb begin
      case (cmd.mul_term)
         TERM_ADD: begin
            ecol = (col == 2'd2) ? 2'd0 : col + 2'd1;
            axis = (col == 2'd0) ? 2'd2 : col - 2'd1;
         end
         TERM_SUB: begin
            ecol = (col == 2'd0) ? 2'd2 : col - 2'd1;
            axis = (col == 2'd2) ? 2'd0 : col + 2'd1;
         end
         default: begin
            ecol = col;
            axis = 2'd0;
         end
      endcase
   end

   assign midx = base + {2'b00, ecol};

   // Clamp c.x to one before asin
   always_comb begin
      if (nm_ff[6] > ONE_Q30)
         cq = ONE_Q30;
      else if (nm_ff[6] < -ONE_Q30)
         cq = -ONE_Q30;
      else
         cq = nm_ff[6];
   end

   // Multiplier operands
   always_comb begin
      if (cmd.sq_go) begin
         mul_a = cq;
         mul_b = cq;
      end else begin
         mul_a = mat_ff[midx];
         mul_b = (cmd.mul_term == TERM_SELF) ? ONE_Q30 : rate_ff[axis];
      end
   end

   // Round the product to Q.30, halves away from zero
   assign prod_bias = prod_ff + HALF_LSB
                      - $signed({{(PROD_W-1){1'b0}}, prod_ff[PROD_W-1]});
   assign rnd_full  = prod_bias >>> FRAC_SH;
   assign rnd       = rnd_full[RND_W-1:0];
   assign diff      = acc_ff - ACC_W'(rnd);

   // Square root step, one result bit per cycle
   assign sshift = 6'd62 - {scnt_ff, 1'b0};
   assign sbit   = SQ_W'(1) << sshift;
   assign trial  = r_ff + sbit;

   // Hold inputs, multiply, accumulate element updates
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         rate_ff[0] <= rate_x;
         rate_ff[1] <= rate_y;
         rate_ff[2] <= rate_z;
      end
      prod_ff  <= mul_a * mul_b;
      pelem_ff <= cmd.mul_elem;
      pterm_ff <= cmd.mul_term;
      if (pvalid_ff) begin
         case (pterm_ff)
            TERM_SELF: acc_ff <= ACC_W'(rnd);
            TERM_ADD:  acc_ff <= acc_ff + ACC_W'(rnd);
            TERM_SUB: begin
               if (diff > EL_MAX)
                  nm_ff[pelem_ff] <= EL_MAX[DATA_WIDTH-1:0];
               else if (diff < EL_MIN)
                  nm_ff[pelem_ff] <= EL_MIN[DATA_WIDTH-1:0];
               else
                  nm_ff[pelem_ff] <= diff[DATA_WIDTH-1:0];
            end
            default:   acc_ff <= acc_ff;
         endcase
      end
      if (cmd.sqrt_init) begin
         v_ff    <= ONE_SQ - prod_ff;
         r_ff    <= '0;
         scnt_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + sbit;
         end else begin
            r_ff <= r_ff >> 1;
         end
         scnt_ff <= scnt_ff + 1'b1;
      end
   end

   // Control flags and the matrix itself
   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         sat_ff    <= 1'b0;
         for (int i = 0; i < 9; i++)
            mat_ff[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
      end else begin
         pvalid_ff <= cmd.mul_go;
         if (cmd.load_in)
            sat_ff <= 1'b0;
         else if (pvalid_ff && pterm_ff == TERM_SUB && (diff > EL_MAX || diff < EL_MIN))
            sat_ff <= 1'b1;
         if (cmd.commit)
            for (int i = 0; i < 9; i++)
               mat_ff[i] <= nm_ff[i];
      end
   end

   // CORDIC operands per angle
   always_comb begin
      case (cmd.ang)
         ANG_ROLL:  begin cy = mat_ff[7]; cx = mat_ff[8]; end
         ANG_PITCH: begin cy = cq;        cx = r_ff[DATA_WIDTH-1:0]; end
         default:   begin cy = mat_ff[3]; cx = mat_ff[0]; end
      endcase
   end

   dgi_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cmd.cordic_go),
      .y_in  (cy),
      .x_in  (cx),
      .done  (cdone),
      .angle (cangle)
   );

   // Capture angles, then the output register
   always_ff @(posedge clock) begin
      if (cdone) begin
         case (cmd.ang)
            ANG_ROLL:  roll_ff  <= sat_ang(-(ZW+1)'(cangle));
            ANG_PITCH: pitch_ff <= sat_ang((ZW+1)'(cangle));
            default:   yaw_ff   <= sat_ang((ZW+1)'(cangle));
         endcase
      end
      if (cmd.out_load) begin
         roll_out_ff  <= roll_ff;
         pitch_out_ff <= pitch_ff;
         yaw_out_ff   <= yaw_ff;
         sat_out_ff   <= sat_ff;
      end
   end

   assign stat.sqrt_last   = (scnt_ff == SQRT_CNT_W'(31));
   assign stat.cordic_done = cdone;
   assign roll_angle       = roll_out_ff;
   assign pitch_angle      = pitch_out_ff;
   assign yaw_angle        = yaw_out_ff;
   assign matrix_saturated = sat_out_ff;

endmodule
`default_nettype wire

// ===== hdl/dgi_ctrl.sv =====
// Controller: sequences the matrix update, square root and the three CORDIC runs.
`default_nettype none
module dgi_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire dgi_pkg::dgi_stat_type stat,
   output      dgi_pkg::dgi_cmd_type  cmd
);
   import dgi_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MUL    = 9'b000000010,
      S_DRAIN  = 9'b000000100,
      S_COMMIT = 9'b000001000,
      S_SQLOAD = 9'b000010000,
      S_SQRT   = 9'b000100000,
      S_CGO    = 9'b001000000,
      S_CRUN   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] elem_ff, elem_in;
   term_type   term_ff, term_in;
   angle_type  ang_ff, ang_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      elem_in  = elem_ff;
      term_in  = term_ff;
      ang_in   = ang_ff;
      cmd           = '0;
      cmd.mul_elem  = elem_ff;
      cmd.mul_term  = term_ff;
      cmd.ang       = ang_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               elem_in     = '0;
               term_in     = TERM_SELF;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            case (term_ff)
               TERM_SELF: term_in = TERM_ADD;
               TERM_ADD:  term_in = TERM_SUB;
               default: begin
                  term_in = TERM_SELF;
                  elem_in = elem_ff + 1'b1;
                  if (elem_ff == 4'd8)
                     state_in = S_DRAIN;
               end
            endcase
         end
         S_DRAIN:  state_in = S_COMMIT;
         S_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.sq_go  = 1'b1;
            state_in   = S_SQLOAD;
         end
         S_SQLOAD: begin
            cmd.sqrt_init = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_last) begin
               ang_in   = ANG_ROLL;
               state_in = S_CGO;
            end
         end
         S_CGO: begin
            cmd.cordic_go = 1'b1;
            state_in      = S_CRUN;
         end
         S_CRUN: begin
            if (stat.cordic_done) begin
               case (ang_ff)
                  ANG_ROLL:  begin ang_in = ANG_PITCH; state_in = S_CGO; end
                  ANG_PITCH: begin ang_in = ANG_YAW;   state_in = S_CGO; end
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result valid until the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      term_ff <= term_in;
      ang_ff  <= ang_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in flight");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before transfer");
   a_elem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (elem_ff <= 4'd8))
      else $error("matrix element index out of range");
   a_drain_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> ($past(state_ff) == S_MUL && $past(elem_ff) == 4'd8))
      else $error("drain entered before the last product");
`endif

endmodule
`default_nettype wire

// ===== hdl/dcm_gyro_integrate_euler_unit.sv =====
// Top level of the gyro-driven rotation matrix update with roll, pitch and yaw readout.
`default_nettype none
// Each request transfer carries one gyro angle increment; the block adds each row
// cross the increment to the 3x3 rotation matrix (reset to identity, elements
// saturated in Q2.30) and returns one response with roll, pitch and yaw in Q3.29
// radians plus a flag for any clipped element. One item is worked on at a time,
// and the next request can be taken in the same cycle in which the previous
// response becomes valid. The work is serialised by the single multiplier
// (27 products for the matrix and one square), the bit-serial square root for
// asin and one CORDIC unit shared by the three angles. A finished response
// waits in an output register while the next request is taken.
module dcm_gyro_integrate_euler_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output      logic                         req_tready,
   // rate_x[31:0], rate_y[63:32], rate_z[95:64]
   input  wire logic [dgi_pkg::REQ_W-1:0]    req_tdata,
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   // roll_angle[31:0], pitch_angle[63:32], yaw_angle[95:64],
   // matrix_saturated[96], zero fill[103:97]
   output      logic [dgi_pkg::RSP_W-1:0]    rsp_tdata
);
   import dgi_pkg::*;

   dgi_cmd_type             cmd;
   dgi_stat_type            stat;
   logic signed [ANG_W-1:0] roll_angle, pitch_angle, yaw_angle;
   logic                    matrix_saturated;

   dgi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dgi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .rate_x           ($signed(req_tdata[31:0])),
      .rate_y           ($signed(req_tdata[63:32])),
      .rate_z           ($signed(req_tdata[95:64])),
      .roll_angle       (roll_angle),
      .pitch_angle      (pitch_angle),
      .yaw_angle        (yaw_angle),
      .matrix_saturated (matrix_saturated)
   );

   // Pack the response
   assign rsp_tdata = {7'd0, matrix_saturated, yaw_angle, pitch_angle, roll_angle};

endmodule
`default_nettype wire

// ===== bench/dcm_gyro_integrate_euler_unit_tb.sv =====
// Self-checking bench for the rotation matrix update with roll, pitch and yaw readout.
`timescale 1ns / 1ps
`default_nettype none
module dcm_gyro_integrate_euler_unit_tb;
   import dgi_pkg::*;

   typedef struct {
      logic signed [RATE_W-1:0] rx;
      logic signed [RATE_W-1:0] ry;
      logic signed [RATE_W-1:0] rz;
   } gyro_step_type;

   typedef struct {
      logic [ANG_W-1:0] roll;
      logic [ANG_W-1:0] pitch;
      logic [ANG_W-1:0] yaw;
      logic             sat;
   } attitude_type;

   localparam int  N_RANDOM     = 1330;
   localparam int  PAUSE_AT     = 700;
   localparam int  HOLD_AT      = 300;
   localparam int  HOLD_CYCLES  = 3000;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   gyro_step_type gyro_queue[$];
   attitude_type  attitude_queue[$];
   gyro_step_type gyro_in_flight;

   longint dcm[9];
   longint atan_lut[40];
   longint half_pi_q29;
   int     mismatches = 0;
   int     steps_sent = 0;
   int     rsp_seen = 0;
   int     req_gap = 0;
   int     rsp_gap = 0;
   int     hold_left = 0;
   bit     hold_done = 1'b0;
   longint cycles = 0;

   dcm_gyro_integrate_euler_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Arctangent series in Q.62
   function automatic longint unsigned arctan_inv(longint unsigned n);
      longint unsigned p, acc, k, t;
      p = (64'd1 << 62) / n;
      acc = 0;
      k = 0;
      while (p != 0) begin
         t = p / (2 * k + 1);
         if (k[0] == 1'b0) acc += t; else acc -= t;
         p /= n * n;
         k++;
      end
      return acc;
   endfunction

   function automatic void build_atan_lut();
      longint unsigned qpi, acc, k, t;
      qpi = 4 * arctan_inv(5) - arctan_inv(239);
      atan_lut[0] = longint'((qpi + (64'd1 << 32)) >> 33);
      half_pi_q29 = longint'((2 * qpi + (64'd1 << 32)) >> 33);
      for (int i = 1; i < 40; i++) begin
         acc = 0;
         k = 0;
         while (i * (2 * k + 1) <= 62) begin
            t = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
            if (k[0] == 1'b0) acc += t; else acc -= t;
            k++;
         end
         atan_lut[i] = longint'((acc + (64'd1 << 32)) >> 33);
      end
   endfunction

   // Product shifted down by 30, rounded half away from zero
   function automatic longint scaled_prod(longint e, longint g);
      longint p;
      longint unsigned m;
      p = e * g;
      m = (p < 0) ? longint'(-p) : p;
      m = (m + (64'd1 << 29)) >> 30;
      return (p < 0) ? -longint'(m) : longint'(m);
   endfunction

   // Vectoring CORDIC on Q.30 inputs, angle in Q3.29
   function automatic longint vector_angle(longint y30, longint x30);
      longint x, y, z, t, dx, dy;
      x = x30 <<< 20;
      y = y30 <<< 20;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = half_pi_q29;
         end else begin
            x = -y; y = t; z = -half_pi_q29;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 40; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_lut[i];
         end else begin
            x -= dx; y += dy; z -= atan_lut[i];
         end
      end
      return z;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [ANG_W-1:0] clip_angle(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[ANG_W-1:0];
   endfunction

   // Apply one gyro increment to the matrix and derive the expected angles
   function automatic attitude_type integrate_step(gyro_step_type s);
      attitude_type a;
      longint nm[9];
      longint gx, gy, gz, x, y, z, hi, lo, cx, sq;
      gx = s.rx;
      gy = s.ry;
      gz = s.rz;
      hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -hi - 1;
      a.sat = 1'b0;
      for (int r = 0; r < 3; r++) begin
         x = dcm[3*r]; y = dcm[3*r+1]; z = dcm[3*r+2];
         nm[3*r]   = x + (scaled_prod(y, gz) - scaled_prod(z, gy));
         nm[3*r+1] = y + (scaled_prod(z, gx) - scaled_prod(x, gz));
         nm[3*r+2] = z + (scaled_prod(x, gy) - scaled_prod(y, gx));
      end
      for (int j = 0; j < 9; j++) begin
         if (nm[j] > hi) begin nm[j] = hi; a.sat = 1'b1; end
         if (nm[j] < lo) begin nm[j] = lo; a.sat = 1'b1; end
         dcm[j] = nm[j];
      end
      a.roll = clip_angle(-vector_angle(nm[7], nm[8]));
      cx = nm[6];
      if (cx > (longint'(1) <<< 30)) cx = longint'(1) <<< 30;
      if (cx < -(longint'(1) <<< 30)) cx = -(longint'(1) <<< 30);
      sq = longint'(floor_sqrt((64'd1 << 60) - longint'(cx * cx)));
      a.pitch = clip_angle(vector_angle(cx, sq));
      a.yaw = clip_angle(vector_angle(nm[3], nm[0]));
      return a;
   endfunction

   function automatic logic [RATE_W-1:0] random_rate();
      int unsigned sel;
      logic [RATE_W-1:0] m;
      sel = $urandom_range(0, 99);
      if (sel < 75) m = $urandom_range(0, 1 << 22);
      else if (sel < 90) m = $urandom_range(0, 1 << 28);
      else return $urandom;
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic int random_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic gyro_step_type make_step(logic [RATE_W-1:0] x, logic [RATE_W-1:0] y,
                                               logic [RATE_W-1:0] z);
      gyro_step_type s;
      s.rx = x; s.ry = y; s.rz = z;
      return s;
   endfunction

   // Drive request transfers from the pending queue
   always @(posedge clock) begin
      logic          nxt_valid;
      gyro_step_type s;
      nxt_valid = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            attitude_queue.push_back(integrate_step(gyro_in_flight));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (steps_sent == PAUSE_AT && attitude_queue.size() != 0) begin
               // hold until every outstanding response has come back
            end else if (gyro_queue.size() != 0) begin
               s = gyro_queue.pop_front();
               gyro_in_flight <= s;
               req_tdata <= {s.rz, s.ry, s.rx};
               nxt_valid = 1'b1;
               steps_sent++;
               req_gap = random_gap();
            end
         end
      end
      req_valid_update(nxt_valid);
   end

   task automatic req_valid_update(logic v);
      req_tvalid <= v;
   endtask

   // Accept and check response transfers, with random and one long hold-off
   always @(posedge clock) begin
      attitude_type e;
      logic [ANG_W-1:0] roll, pitch, yaw;
      logic sat;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            roll  = rsp_tdata[31:0];
            pitch = rsp_tdata[63:32];
            yaw   = rsp_tdata[95:64];
            sat   = rsp_tdata[96];
            rsp_seen++;
            if (attitude_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %0d: roll %h pitch %h yaw %h sat %b",
                           rsp_seen, roll, pitch, yaw, sat);
            end else begin
               e = attitude_queue.pop_front();
               if (roll !== e.roll || pitch !== e.pitch || yaw !== e.yaw || sat !== e.sat)
               begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d: exp roll %h pitch %h yaw %h sat %b, got %h %h %h %b",
                              rsp_seen, e.roll, e.pitch, e.yaw, e.sat, roll, pitch, yaw, sat);
               end
            end
         end
         if (!hold_done && rsp_seen == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap = ($urandom_range(0, 3) == 0) ? random_gap() : 0;
         end
      end
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("dcm_gyro_integrate_euler_unit verification failed");
         $finish;
      end
   end

   initial begin
      logic [RATE_W-1:0] mx, mn;
      build_atan_lut();
      for (int j = 0; j < 9; j++) dcm[j] = (j % 4 == 0) ? (longint'(1) <<< 30) : 0;
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      // Directed: zero, tiny steps, single-axis extremes, then clamping runs
      gyro_queue.push_back(make_step(0, 0, 0));
      gyro_queue.push_back(make_step(1, 0, 0));
      gyro_queue.push_back(make_step(0, 32'hFFFF_FFFF, 0));
      gyro_queue.push_back(make_step(0, 0, 1 << 29));
      gyro_queue.push_back(make_step(32'h2000_0000, 0, 0));
      gyro_queue.push_back(make_step(0, 32'hE000_0000, 0));
      gyro_queue.push_back(make_step(mx, 0, 0));
      gyro_queue.push_back(make_step(0, mx, 0));
      gyro_queue.push_back(make_step(0, 0, mx));
      gyro_queue.push_back(make_step(mn, 0, 0));
      gyro_queue.push_back(make_step(0, mn, 0));
      gyro_queue.push_back(make_step(0, 0, mn));
      gyro_queue.push_back(make_step(mx, mx, mx));
      gyro_queue.push_back(make_step(mn, mn, mn));
      gyro_queue.push_back(make_step(mx, mn, mx));
      gyro_queue.push_back(make_step(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0));
      gyro_queue.push_back(make_step(0, 0, 0));
      gyro_queue.push_back(make_step(0, 0, 1 << 30));
      gyro_queue.push_back(make_step(0, 0, 1 << 30));
      gyro_queue.push_back(make_step(1 << 30, 0, 0));
      for (int i = 0; i < N_RANDOM; i++)
         gyro_queue.push_back(make_step(random_rate(), random_rate(), random_rate()));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Drain stimulus, then outstanding responses
      wait (gyro_queue.size() == 0 && !req_tvalid);
      wait (attitude_queue.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && attitude_queue.size() == 0)
         $display("dcm_gyro_integrate_euler_unit verification clean");
      else
         $display("dcm_gyro_integrate_euler_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire
